[rtl/pid_windowed_integral_deadband_defines.svh]
// Assertion helpers for the bind checker of this block.
`ifndef PID_WINDOWED_INTEGRAL_DEADBAND_DEFINES_SVH
`define PID_WINDOWED_INTEGRAL_DEADBAND_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define PIDWIN_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PIDWIN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/pidwin_pkg.sv]
`timescale 1ns / 1ps

package pidwin_pkg;

    // Field widths of the sample, result and configuration channels.
    localparam int DATA_W = 16;
    localparam int ERR_W  = DATA_W + 1;
    localparam int CFG_IDX_W = 3;

    // Default depth of the error window.
    localparam int WINDOW_DEF = 100;

    // Register map of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP       = 3'd0,
        CFG_KI_DT    = 3'd1,
        CFG_KD_DT    = 3'd2,
        CFG_OUT_MAX  = 3'd3,
        CFG_OUT_MIN  = 3'd4,
        CFG_DEADBAND = 3'd5
    } t_cfg_idx;

    // Register values after reset.
    localparam logic signed [DATA_W-1:0] KP_RST       = 16'sd256;
    localparam logic signed [DATA_W-1:0] KI_DT_RST    = 16'sd0;
    localparam logic signed [DATA_W-1:0] KD_DT_RST    = 16'sd0;
    localparam logic signed [DATA_W-1:0] OUT_MAX_RST  = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0] OUT_MIN_RST  = 16'sh8000;
    localparam logic        [DATA_W-1:0] DEADBAND_RST = 16'd0;

    // Gains are Q8.8: the result is rounded half up and shifted by this many bits.
    localparam int FRAC_W = 8;

endpackage

[rtl/pid_windowed_integral_deadband.sv]
`timescale 1ns / 1ps
// Channel   | Direction | Handshake                   | Payload
// ----------+-----------+-----------------------------+----------------------------------
// sample    | in        | i_in_valid / o_in_stall     | i_target, i_measured
// result    | out       | o_out_valid / i_out_stall   | o_drive, o_in_deadband
// config    | in        | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// One request is taken every cycle while o_in_stall is low; it moves through the stage registers
// into the output register. The rate is set by the error ring memory, read and written at the
// same entry in the accept cycle, and by the running sum, updated once per non-deadband request.
// Reset is synchronous and active low; it loads the register defaults and clears the
// pipeline, the pointers and the sum. The ring needs no clearing pass.
// A stall on the result side fills the pipeline stage by stage before o_in_stall rises.

module pid_windowed_integral_deadband #(
    parameter int WINDOW = pidwin_pkg::WINDOW_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,

    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic signed [pidwin_pkg::DATA_W-1:0]    i_target,
    input  logic signed [pidwin_pkg::DATA_W-1:0]    i_measured,

    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [pidwin_pkg::DATA_W-1:0]    o_drive,
    output logic                                    o_in_deadband,

    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic        [pidwin_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [pidwin_pkg::DATA_W-1:0]    i_cfg_data
);

    localparam int DATA_W = pidwin_pkg::DATA_W;
    localparam int ERR_W  = pidwin_pkg::ERR_W;
    localparam int DIFF_W = ERR_W + 1;
    localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W = $clog2(WINDOW + 1);
    // The sum of WINDOW errors never exceeds WINDOW times the largest error magnitude.
    localparam int SUM_W  = ERR_W + $clog2(WINDOW);
    localparam int PKP_W  = DATA_W + ERR_W;
    localparam int PKD_W  = DATA_W + DIFF_W;
    localparam int PKI_W  = DATA_W + SUM_W;
    localparam int ACC_W  = PKI_W + 2;
    localparam int FRAC_W = pidwin_pkg::FRAC_W;
    localparam int Q_W    = ACC_W - FRAC_W;

    localparam logic [POS_W-1:0]         LAST_POS = POS_W'(WINDOW - 1);
    localparam logic [FILL_W-1:0]        FULL_CNT = FILL_W'(WINDOW);
    localparam logic signed [ACC_W-1:0]  RND_HALF = ACC_W'(1 << (FRAC_W - 1));

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken.
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] r_kp;
    logic signed [DATA_W-1:0] r_ki_dt;
    logic signed [DATA_W-1:0] r_kd_dt;
    logic signed [DATA_W-1:0] r_out_max;
    logic signed [DATA_W-1:0] r_out_min;
    logic        [DATA_W-1:0] r_deadband;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp       <= pidwin_pkg::KP_RST;
            r_ki_dt    <= pidwin_pkg::KI_DT_RST;
            r_kd_dt    <= pidwin_pkg::KD_DT_RST;
            r_out_max  <= pidwin_pkg::OUT_MAX_RST;
            r_out_min  <= pidwin_pkg::OUT_MIN_RST;
            r_deadband <= pidwin_pkg::DEADBAND_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                pidwin_pkg::CFG_KP:       r_kp       <= i_cfg_data;
                pidwin_pkg::CFG_KI_DT:    r_ki_dt    <= i_cfg_data;
                pidwin_pkg::CFG_KD_DT:    r_kd_dt    <= i_cfg_data;
                pidwin_pkg::CFG_OUT_MAX:  r_out_max  <= i_cfg_data;
                pidwin_pkg::CFG_OUT_MIN:  r_out_min  <= i_cfg_data;
                pidwin_pkg::CFG_DEADBAND: r_deadband <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow. Each stage loads when it is empty or when the stage
    // after it loads, so bubbles collapse and a full output register only
    // blocks the input once every stage is occupied.
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4, r_out_valid;
    logic w_ld1, w_ld2, w_ld3, w_ld4, w_ld_out;
    logic w_accept;

    assign w_ld_out   = !r_out_valid || !i_out_stall;
    assign w_ld4      = !r_v4 || w_ld_out;
    assign w_ld3      = !r_v3 || w_ld4;
    assign w_ld2      = !r_v2 || w_ld3;
    assign w_ld1      = !r_v1 || w_ld2;
    assign o_in_stall = !w_ld1;
    assign w_accept   = i_in_valid && w_ld1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_ld1) begin
                r_v1 <= w_accept;
            end
            if (w_ld2) begin
                r_v2 <= r_v1;
            end
            if (w_ld3) begin
                r_v3 <= r_v2;
            end
            if (w_ld4) begin
                r_v4 <= r_v3;
            end
            if (w_ld_out) begin
                r_out_valid <= r_v4;
            end
        end
    end

    // ------------------------------------------------------------------
    // Accept stage: error, deadband test, ring pointers and ring access.
    // ------------------------------------------------------------------
    logic signed [ERR_W-1:0] w_err;
    logic signed [ERR_W-1:0] w_db_pos;
    logic signed [ERR_W-1:0] w_db_neg;
    logic                    w_in_db;
    logic                    w_update;

    assign w_err    = $signed({i_target[DATA_W-1], i_target})
                    - $signed({i_measured[DATA_W-1], i_measured});
    assign w_db_pos = $signed({1'b0, r_deadband});
    assign w_db_neg = -w_db_pos;
    // |error| < deadband, written as two compares; a zero deadband never matches.
    assign w_in_db  = (w_err < w_db_pos) && (w_err > w_db_neg);
    assign w_update = w_accept && !w_in_db;

    logic [POS_W-1:0]  r_ring_pos;
    logic [FILL_W-1:0] r_fill_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_pos   <= '0;
            r_fill_count <= '0;
        end else if (w_update) begin
            r_ring_pos <= (r_ring_pos == LAST_POS) ? '0 : r_ring_pos + 1'b1;
            if (r_fill_count != FULL_CNT) begin
                r_fill_count <= r_fill_count + 1'b1;
            end
        end
    end

    // The ring is read and written at the same entry in the same cycle. The
    // read returns the old contents, which is the oldest error once the ring
    // has filled. Entries are only consumed after all of them were written.
    logic signed [ERR_W-1:0] r_ring [WINDOW];
    logic signed [ERR_W-1:0] r_s1_old;

    always_ff @(posedge i_clk) begin
        if (w_update) begin
            r_s1_old           <= r_ring[r_ring_pos];
            r_ring[r_ring_pos] <= w_err;
        end
    end

    logic signed [ERR_W-1:0] r_s1_err;
    logic                    r_s1_db;
    logic                    r_s1_full;

    always_ff @(posedge i_clk) begin
        if (w_ld1) begin
            r_s1_err  <= w_err;
            r_s1_db   <= w_in_db;
            r_s1_full <= (r_fill_count == FULL_CNT);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: running sum and derivative difference. The state updates
    // when the request moves on, so the next request sees it at once.
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0]  r_ring_sum;
    logic signed [ERR_W-1:0]  r_last_error;
    logic signed [ERR_W-1:0]  w_old_sub;
    logic signed [SUM_W-1:0]  n_ring_sum;
    logic signed [DIFF_W-1:0] w_diff;
    logic                     w_s1_commit;

    assign w_old_sub   = r_s1_full ? r_s1_old : '0;
    assign n_ring_sum  = r_ring_sum + SUM_W'(r_s1_err) - SUM_W'(w_old_sub);
    assign w_diff      = DIFF_W'(r_s1_err) - DIFF_W'(r_last_error);
    assign w_s1_commit = r_v1 && w_ld2 && !r_s1_db;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_sum   <= '0;
            r_last_error <= '0;
        end else if (w_s1_commit) begin
            r_ring_sum   <= n_ring_sum;
            r_last_error <= r_s1_err;
        end
    end

    logic signed [ERR_W-1:0]  r_s2_err;
    logic signed [DIFF_W-1:0] r_s2_diff;
    logic signed [SUM_W-1:0]  r_s2_sum;
    logic                     r_s2_db;

    always_ff @(posedge i_clk) begin
        if (w_ld2) begin
            r_s2_err  <= r_s1_err;
            r_s2_diff <= w_diff;
            r_s2_sum  <= n_ring_sum;
            r_s2_db   <= r_s1_db;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the three gain products, each registered.
    // ------------------------------------------------------------------
    logic signed [PKP_W-1:0] r_s3_pkp;
    logic signed [PKD_W-1:0] r_s3_pkd;
    logic signed [PKI_W-1:0] r_s3_pki;
    logic                    r_s3_db;

    always_ff @(posedge i_clk) begin
        if (w_ld3) begin
            r_s3_pkp <= r_kp * r_s2_err;
            r_s3_pkd <= r_kd_dt * r_s2_diff;
            r_s3_pki <= r_ki_dt * r_s2_sum;
            r_s3_db  <= r_s2_db;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sum of terms, round half up, drop the fraction (floor).
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] w_acc;
    logic signed [Q_W-1:0]   r_s4_q;
    logic                    r_s4_db;

    assign w_acc = ACC_W'(r_s3_pkp) + ACC_W'(r_s3_pkd) + ACC_W'(r_s3_pki) + RND_HALF;

    always_ff @(posedge i_clk) begin
        if (w_ld4) begin
            r_s4_q  <= w_acc[ACC_W-1:FRAC_W];
            r_s4_db <= r_s3_db;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: clamp into the output register. The upper limit applies
    // first, so a lower limit above the upper one wins.
    // ------------------------------------------------------------------
    logic signed [Q_W-1:0]    w_hi;
    logic signed [Q_W-1:0]    w_lim;
    logic signed [DATA_W-1:0] r_drive;
    logic                     r_out_db;

    assign w_hi  = (r_s4_q > Q_W'(r_out_max)) ? Q_W'(r_out_max) : r_s4_q;
    assign w_lim = (w_hi < Q_W'(r_out_min)) ? Q_W'(r_out_min) : w_hi;

    always_ff @(posedge i_clk) begin
        if (w_ld_out) begin
            r_drive  <= r_s4_db ? '0 : w_lim[DATA_W-1:0];
            r_out_db <= r_s4_db;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_drive       = r_drive;
    assign o_in_deadband = r_out_db;

endmodule

[rtl/pidwin_chk.sv]
`timescale 1ns / 1ps
`include "pid_windowed_integral_deadband_defines.svh"

module pidwin_chk (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_stall,
    input logic                                 o_out_valid,
    input logic                                 i_out_stall,
    input logic signed [pidwin_pkg::DATA_W-1:0] o_drive,
    input logic                                 o_in_deadband
);

    logic w_in_req;

    assign w_in_req = i_in_valid && !o_in_stall;

    // A stalled result keeps its value until taken.
    `PIDWIN_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_drive) && $stable(o_in_deadband), "stalled result changed")
    // A result inside the deadband carries a zero drive.
    `PIDWIN_ASSERT_IMPL(a_db_zero, i_clk, i_rst_n, o_out_valid && o_in_deadband, o_drive == '0, "deadband result with nonzero drive")
    // The input only stalls when the output register is full and held.
    `PIDWIN_ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall, "input stalled with output free")
    // With no output stall, a request moves through every stage without a hold and reaches the output.
    `PIDWIN_ASSERT_NEXT(a_latency, i_clk, i_rst_n, w_in_req ##1 !i_out_stall ##1 !i_out_stall ##1 !i_out_stall ##1 !i_out_stall, o_out_valid, "result missing after pipeline latency")

endmodule

bind pid_windowed_integral_deadband pidwin_chk u_pidwin_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_drive       (o_drive),
    .o_in_deadband (o_in_deadband)
);

[tb/pid_windowed_integral_deadband_checker.sv]
`timescale 1ns / 1ps

// Watches the sample, result and register channels, predicts each drive value
// and compares it with what the block returns.
module pid_windowed_integral_deadband_checker
    import pidwin_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_stall,
    input  logic signed [DATA_W-1:0] i_target,
    input  logic signed [DATA_W-1:0] i_measured,
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  logic signed [DATA_W-1:0] i_drive,
    input  logic                     i_in_deadband,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [DATA_W-1:0]        i_cfg_data,
    output int                       o_fail_count,
    output int                       o_pending
);

    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        logic                     in_db;
    } t_drive_res;

    // Local copy of the register file.
    logic signed [DATA_W-1:0] kp_r, ki_r, kd_r, hi_r, lo_r;
    logic        [DATA_W-1:0] db_r;

    // Controller state.
    int     prev_err;
    int     err_hist [WINDOW];
    longint hist_total;
    int     hist_fill;
    int     hist_pos;

    t_drive_res pending_drives [$];
    int fails    = 0;
    int seen     = 0;
    int pend_cnt = 0;

    assign o_fail_count = fails;
    assign o_pending    = pend_cnt;

    function automatic t_drive_res predict_drive(input logic signed [DATA_W-1:0] tgt,
                                                 input logic signed [DATA_W-1:0] meas);
        int         err;
        int         mag;
        int         slot;
        longint     acc;
        longint     val;
        t_drive_res res;
        err = int'(tgt) - int'(meas);
        mag = (err < 0) ? -err : err;
        if (mag < int'(db_r)) begin
            res.drive = '0;
            res.in_db = 1'b1;
            return res;
        end
        // Once the window is full the oldest error leaves the sum.
        slot = hist_pos;
        if (hist_fill >= WINDOW) begin
            hist_total -= err_hist[slot];
        end else begin
            hist_fill++;
        end
        err_hist[slot] = err;
        hist_total += err;
        hist_pos = (slot + 1 >= WINDOW) ? 0 : slot + 1;

        acc = longint'(kp_r) * err + longint'(kd_r) * (err - prev_err)
            + longint'(ki_r) * hist_total;
        prev_err = err;

        val = (acc + 128) >>> FRAC_W;
        if (val > longint'(hi_r)) begin
            val = longint'(hi_r);
        end
        if (val < longint'(lo_r)) begin
            val = longint'(lo_r);
        end
        res.drive = val[DATA_W-1:0];
        res.in_db = 1'b0;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_drive_res want;
        if (!i_rst_n) begin
            kp_r = KP_RST;
            ki_r = KI_DT_RST;
            kd_r = KD_DT_RST;
            hi_r = OUT_MAX_RST;
            lo_r = OUT_MIN_RST;
            db_r = DEADBAND_RST;
            prev_err   = 0;
            hist_total = 0;
            hist_fill  = 0;
            hist_pos   = 0;
            pending_drives.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_KP:       kp_r = i_cfg_data;
                    CFG_KI_DT:    ki_r = i_cfg_data;
                    CFG_KD_DT:    kd_r = i_cfg_data;
                    CFG_OUT_MAX:  hi_r = i_cfg_data;
                    CFG_OUT_MIN:  lo_r = i_cfg_data;
                    CFG_DEADBAND: db_r = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                pending_drives.push_back(predict_drive(i_target, i_measured));
            end
            if (i_out_valid && !i_out_stall) begin
                seen++;
                if (pending_drives.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("result %0d arrived with nothing expected: drive %0d dz %0b",
                                 seen, i_drive, i_in_deadband);
                    end
                end else begin
                    want = pending_drives.pop_front();
                    if (want.drive !== i_drive || want.in_db !== i_in_deadband) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("result %0d: expected drive %0d dz %0b, got drive %0d dz %0b",
                                     seen, want.drive, want.in_db, i_drive, i_in_deadband);
                        end
                    end
                end
            end
        end
        // Outstanding predictions, read by the top to know when the block is idle.
        pend_cnt = pending_drives.size();
    end

endmodule

[tb/pid_windowed_integral_deadband_tb.sv]
`timescale 1ns / 1ps

// Top of the bench. It generates clock and reset, programs the gains and
// limits between phases, feeds setpoint/measurement requests and paces the
// result side. All checking lives in the checker instance; this module only
// reads its failure count and its count of outstanding predictions.
module pid_windowed_integral_deadband_tb;

    import pidwin_pkg::*;

    // Register indexes past the end of the map; writes to them must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam int PHASES        = 6;
    localparam int PER_PHASE     = 200;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 20;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic signed [DATA_W-1:0] i_target = '0;
    logic signed [DATA_W-1:0] i_measured = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [DATA_W-1:0] o_drive;
    logic                     o_in_deadband;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [DATA_W-1:0]        i_cfg_data = '0;

    int fail_count;
    int pending;

    // Pacing knobs, in percent of cycles.
    int gap_pct   = 0;
    int stall_pct = 0;

    // Deadband currently programmed; the sample generator aims near it.
    int cur_db = 0;

    int cycles = 0;
    int sent = 0;
    int settings = 0;

    always #5 i_clk = ~i_clk;

    pid_windowed_integral_deadband uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_target      (i_target),
        .i_measured    (i_measured),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_drive       (o_drive),
        .o_in_deadband (o_in_deadband),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    pid_windowed_integral_deadband_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_target      (i_target),
        .i_measured    (i_measured),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_drive       (o_drive),
        .i_in_deadband (o_in_deadband),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // The result side stalls at random; the rate is set per phase.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Watchdog. A hang or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Sends one request. Idle cycles are inserted before it at the sender's
    // rate, and the payload holds until the block accepts it. Valid is
    // assigned once per falling edge, so back-to-back requests never see a
    // low-then-high pair in the same step.
    task automatic send_sample(input logic signed [DATA_W-1:0] tgt,
                               input logic signed [DATA_W-1:0] meas);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_target   <= tgt;
        i_measured <= meas;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        sent++;
    endtask

    // Drops valid and waits until every predicted result has come back. Since
    // every request produces exactly one result, the block is idle then.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[DATA_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(input int kp, input int ki, input int kd,
                                 input int hi, input int lo, input int db);
        write_reg(CFG_KP, kp);
        write_reg(CFG_KI_DT, ki);
        write_reg(CFG_KD_DT, kd);
        write_reg(CFG_OUT_MAX, hi);
        write_reg(CFG_OUT_MIN, lo);
        write_reg(CFG_DEADBAND, db);
        cur_db = db;
        settings++;
    endtask

    // Builds one random request. Half are well formed with an error close to
    // the deadband edge or small enough to keep the integral away from the
    // rails; the rest are full-range noise and corner values.
    task automatic make_sample(output logic signed [DATA_W-1:0] tgt,
                               output logic signed [DATA_W-1:0] meas);
        int kind;
        int m;
        int t;
        int delta;
        bit offset;
        kind   = $urandom_range(0, 9);
        m      = $urandom_range(0, 65535) - 32768;
        t      = $urandom_range(0, 65535) - 32768;
        offset = 1'b0;
        delta  = 0;
        if (kind >= 4 && kind <= 6) begin
            delta  = int'($urandom_range(0, 2 * cur_db + 16)) - (cur_db + 8);
            offset = 1'b1;
        end else if (kind >= 7 && kind <= 8) begin
            delta  = int'($urandom_range(0, 128)) - 64;
            offset = 1'b1;
        end else if (kind == 9) begin
            case ($urandom_range(0, 3))
                0: t = 32767;
                1: t = -32768;
                2: t = 0;
                default: t = -1;
            endcase
            case ($urandom_range(0, 3))
                0: m = 32767;
                1: m = -32768;
                2: m = 0;
                default: m = -1;
            endcase
        end
        if (offset) begin
            // Keep the setpoint inside the 16-bit range by flipping the sign
            // of the offset, or drop it when neither direction fits.
            t = m + delta;
            if (t > 32767 || t < -32768) begin
                t = m - delta;
            end
            if (t > 32767 || t < -32768) begin
                t = m;
            end
        end
        tgt  = t[DATA_W-1:0];
        meas = m[DATA_W-1:0];
    endtask

    // One random phase: a register setting, a pacing mode and a batch of
    // requests. The setting is written only after the block has drained.
    task automatic run_phase(input int p);
        logic signed [DATA_W-1:0] tgt;
        logic signed [DATA_W-1:0] meas;
        wait_drained();
        case (p)
            0: apply_setting(256, 0, 0, 32767, -32768, 0);
            1: apply_setting(64, 3, 128, 20000, -20000, 50);
            // Largest gains of both signs, so the sum saturates both ways.
            2: apply_setting(-32768, 32767, -32768, 32767, -32768, 0);
            // Lower limit above the upper one: the lower limit wins.
            3: apply_setting(32767, -32768, 32767, -5, 5, 1);
            4: apply_setting($urandom_range(0, 65535), int'($urandom_range(0, 64)) - 32,
                             $urandom_range(0, 65535), $urandom_range(0, 32767),
                             -int'($urandom_range(0, 32768)), $urandom_range(0, 300));
            default: apply_setting(300, -2, 0, 12000, -300, 1000);
        endcase
        case (p % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 69; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 69; end
            default: begin gap_pct = 22; stall_pct = 22; end
        endcase
        repeat (PER_PHASE) begin
            make_sample(tgt, meas);
            send_sample(tgt, meas);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests at the reset defaults: zero error, the largest
        // errors of both signs (which must clip), and small odd errors.
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sh7FFF, -16'sh8000);
        send_sample(-16'sh8000, 16'sh7FFF);
        send_sample(-16'sh8000, -16'sh8000);
        send_sample(16'sh7FFF, 16'sh7FFF);
        send_sample(16'sd100, -16'sd27);
        send_sample(-16'sd1, 16'sd0);

        // Half gain with a deadband of five. Errors of magnitude four and zero
        // sit inside it; five and seven leave it and exercise the round-half-up
        // rule on both signs.
        wait_drained();
        apply_setting(128, 0, 0, 30000, -30000, 5);
        send_sample(16'sd4, 16'sd0);
        send_sample(16'sd0, 16'sd4);
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd5, 16'sd0);
        send_sample(16'sd0, 16'sd5);
        send_sample(16'sd7, 16'sd0);

        // Widest deadband together with crossed limits: only the largest error
        // magnitude, of either sign, gets through, and it must come out at the lower
        // limit. Writes to indexes past the map must change nothing.
        wait_drained();
        apply_setting(-256, 256, 512, -100, 100, 65535);
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'h0000);
        send_sample(16'sh7FFF, -16'sh8000);
        send_sample(-16'sh8000, 16'sh7FFF);
        send_sample(16'sh7FFE, -16'sh8000);
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd1, -16'sd1);

        for (int p = 0; p < PHASES; p++) begin
            run_phase(p);
        end

        // Let the last results arrive, then watch a little longer so that an
        // extra result from the block would still be caught.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests under %0d gain/limit settings,", sent, settings);
        $display("with free-running, sender-gapped, receiver-stalled and mixed pacing.");
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/pidwin_pkg.sv
rtl/pid_windowed_integral_deadband.sv
rtl/pidwin_chk.sv
tb/pid_windowed_integral_deadband_checker.sv
tb/pid_windowed_integral_deadband_tb.sv
